// File: rtl/pmct_pkg.sv
// Shared types, constants and the delta decoder for the PS/2 cursor tracker.
`timescale 1ns / 1ps

package pmct_pkg;

  // Defaults for top-level parameters
  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  // Cursor sprite size
  localparam logic [CFG_W-1:0] CURSOR_W = 13'd12;
  localparam logic [CFG_W-1:0] CURSOR_H = 13'd19;

  // Header byte bit positions
  localparam int HDR_LEFT_BIT   = 0;
  localparam int HDR_RIGHT_BIT  = 1;
  localparam int HDR_ONE_BIT    = 3;
  localparam int HDR_XSIGN_BIT  = 4;
  localparam int HDR_YSIGN_BIT  = 5;
  localparam int HDR_XOVF_BIT   = 6;
  localparam int HDR_YOVF_BIT   = 7;

  // Decoded delta: -511 .. 510
  localparam int DELTA_W = 10;
  localparam logic signed [DELTA_W-1:0] OVF_ADD = 10'sd255;

  // Packet assembler states
  typedef enum logic [1:0] {
    ST_HDR = 2'd0,
    ST_X   = 2'd1,
    ST_Y   = 2'd2
  } st_t;

  // One complete packet passed from front to back
  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] xmv;
    logic [7:0] ymv;
  } pkt_t;

  // Screen size registers
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } scr_cfg_t;

  // 9-bit two's complement movement plus 255 more on overflow
  function automatic logic signed [DELTA_W-1:0] decode_delta(
    input logic [7:0] mv,
    input logic       neg,
    input logic       ovf
  );
    logic signed [DELTA_W-1:0] base;
    logic signed [DELTA_W-1:0] adj;
    base = {neg, neg, mv};
    adj  = ovf ? (neg ? -OVF_ADD : OVF_ADD) : '0;
    return base + adj;
  endfunction

endpackage

// File: rtl/pmct_front.sv
// Packet assembler: gathers header, X and Y bytes and pushes whole packets.
`timescale 1ns / 1ps

module pmct_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  output logic            q_push,
  input  logic            q_ready,
  output pmct_pkg::pkt_t  q_data
);
  import pmct_pkg::*;

  st_t        state_r, state_nxt;
  logic [7:0] hdr_r;
  logic [7:0] xmv_r;
  logic       acc;
  logic       hdr_ok;

  assign acc    = in_valid && in_ready;
  assign hdr_ok = in_rx_byte[HDR_ONE_BIT];

  // Only the third byte needs room in the queue
  assign in_ready = (state_r != ST_Y) || q_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (acc) begin
      case (state_r)
        ST_HDR:  state_nxt = hdr_ok ? ST_X : ST_HDR;
        ST_X:    state_nxt = ST_Y;
        ST_Y:    state_nxt = ST_HDR;
        default: state_nxt = hdr_ok ? ST_X : ST_HDR;
      endcase
    end
  end

  // Outputs
  always_comb begin
    q_push = 1'b0;
    case (state_r)
      ST_Y:    q_push = acc;
      default: q_push = 1'b0;
    endcase
  end

  assign q_data = '{hdr: hdr_r, xmv: xmv_r, ymv: in_rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stored packet bytes
  always_ff @(posedge clk) begin
    if (acc && (state_r != ST_X) && (state_r != ST_Y) && hdr_ok) begin
      hdr_r <= in_rx_byte;
    end
    if (acc && (state_r == ST_X)) begin
      xmv_r <= in_rx_byte;
    end
  end

`ifndef ASSERT_OFF
  // A pushed packet always sends the assembler back to header hunting
  a_push_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (state_r == ST_HDR))
    else $error("front: not back at header after push");
`endif

endmodule

// File: rtl/pmct_fifo.sv
// Small register queue between the packet assembler and the cursor unit.
`timescale 1ns / 1ps

module pmct_fifo #(
  parameter int DEPTH = pmct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  output logic            wr_ready,
  input  pmct_pkg::pkt_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_en,
  output pmct_pkg::pkt_t  rd_data
);
  import pmct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  // An empty queue has equal read and write pointers
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo: empty but pointers differ");
`endif

endmodule

// File: rtl/pmct_back.sv
// Cursor unit: decodes deltas, moves the cursor with bounds and holds the result.
`timescale 1ns / 1ps

module pmct_back #(
  parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pmct_pkg::scr_cfg_t     scr,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  pmct_pkg::pkt_t         q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  out_cursor_x,
  output logic [COORD_BITS-1:0]  out_cursor_y,
  output logic                   out_left_pressed,
  output logic                   out_right_pressed
);
  import pmct_pkg::*;

  // Wide enough for coordinate plus delta and for size minus cursor
  localparam int CALC_W = COORD_BITS + 6;

  logic                      out_valid_r;
  logic [COORD_BITS-1:0]     pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]     pos_y_r, pos_y_nxt;
  logic                      left_r, right_r;
  logic signed [DELTA_W-1:0] dx, dy;

  // New coordinate, or the old one when it leaves the allowed range
  function automatic logic [COORD_BITS-1:0] move_axis(
    input logic [COORD_BITS-1:0]    old,
    input logic signed [CALC_W-1:0] delta,
    input logic [CFG_W-1:0]         size,
    input logic [CFG_W-1:0]         cur
  );
    logic signed [CALC_W-1:0] nv;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] cmax;
    nv   = signed'({{(CALC_W - COORD_BITS){1'b0}}, old}) + delta;
    lim  = signed'({{(CALC_W - CFG_W){1'b0}}, size})
         - signed'({{(CALC_W - CFG_W){1'b0}}, cur});
    cmax = signed'({{(CALC_W - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
    if (nv < 0 || nv > lim || nv > cmax) return old;
    return nv[COORD_BITS-1:0];
  endfunction

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Delta decode and position update
  always_comb begin
    dx = decode_delta(q_data.xmv, q_data.hdr[HDR_XSIGN_BIT], q_data.hdr[HDR_XOVF_BIT]);
    dy = decode_delta(q_data.ymv, q_data.hdr[HDR_YSIGN_BIT], q_data.hdr[HDR_YOVF_BIT]);
    pos_x_nxt = move_axis(pos_x_r, {{(CALC_W - DELTA_W){dx[DELTA_W-1]}}, dx},
                          scr.width, CURSOR_W);
    // Mouse Y up moves the row up
    pos_y_nxt = move_axis(pos_y_r, -{{(CALC_W - DELTA_W){dy[DELTA_W-1]}}, dy},
                          scr.height, CURSOR_H);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Button bits of the last packet
  always_ff @(posedge clk) begin
    if (q_pop) begin
      left_r  <= q_data.hdr[HDR_LEFT_BIT];
      right_r <= q_data.hdr[HDR_RIGHT_BIT];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = pos_x_r;
  assign out_cursor_y      = pos_y_r;
  assign out_left_pressed  = left_r;
  assign out_right_pressed = right_r;

`ifndef ASSERT_OFF
  // Position only moves when a packet is taken from the queue
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> ($stable(pos_x_r) && $stable(pos_y_r)))
    else $error("back: position changed without a packet");

  // A taken packet always yields a result item
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("back: packet taken but no result");
`endif

endmodule

// File: rtl/ps2_mouse_packet_cursor_tracker_top.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | in_rx_byte[7:0]
//  out      | out_valid / out_ready | out_cursor_x/y, out_left/right_pressed
//  cfg      | cfg_valid / cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
// One byte per cycle in while in_ready is high. A completed packet is written
// to the packet queue; the cursor unit takes it and registers its result.
// Synchronous active-low reset: cursor at 0,0, screen 1024 x 768, hunting
// for a header. in_ready drops only on a third byte while the queue is full;
// a stalled output backs up into the queue, cfg_ready is always high.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_top #(
  parameter int COORD_BITS  = pmct_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = pmct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_BITS-1:0]           out_cursor_x,
  output logic [COORD_BITS-1:0]           out_cursor_y,
  output logic                            out_left_pressed,
  output logic                            out_right_pressed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmct_pkg::CFG_W-1:0]      cfg_data
);
  import pmct_pkg::*;

  scr_cfg_t scr_r;
  logic     q_push, q_ready, q_valid, q_pop;
  pkt_t     q_wdata, q_rdata;

  // Screen size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r.width  <= SCREEN_WIDTH_RST;
      scr_r.height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_r.width  <= cfg_data;
        REG_SCREEN_HEIGHT: scr_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

  pmct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_data     (q_wdata)
  );

  pmct_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_ready (q_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rdata)
  );

  pmct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .scr               (scr_r),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_left_pressed  (out_left_pressed),
    .out_right_pressed (out_right_pressed)
  );

endmodule
